// File: rtl/vertex_normal_generator_assert.svh
// Assertion macros used by the vng_ctrl module.
`ifndef VERTEX_NORMAL_GENERATOR_ASSERT_SVH
`define VERTEX_NORMAL_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset.
`define VNG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define VNG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/vng_pkg.sv
package vng_pkg;

    localparam int VERTEX_SLOTS = 1024;
    localparam int SUM_WIDTH    = 48;
    localparam int ADDR_W       = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;

    localparam int SLOT_W  = 10;
    localparam int POS_W   = 16;
    localparam int PFULL_W = 3 * POS_W;
    localparam int EDGE_W  = POS_W + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int FACE_W  = PROD_W + 1;
    localparam int MAG_LIM = 30;
    localparam int SQP_W   = 2 * MAG_LIM;
    localparam int Q_W     = SQP_W + 2;
    localparam int ROOT_W  = Q_W / 2;
    localparam int REM_W   = ROOT_W + 1;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int FRAC_W  = 14;
    localparam int QUO_W   = FRAC_W + 1;
    localparam int NUM_W   = MAG_LIM + FRAC_W + 1;
    localparam int DREM_W  = ROOT_W;
    localparam int NRM_W   = 16;
    localparam int STEP_W  = 6;

    localparam logic [STEP_W-1:0] POS_LAST  = STEP_W'(3);
    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(6);
    localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(3);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W);
    localparam logic [1:0]        COMP_LAST = 2'd2;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_TRI  = 2'd1,
        ACT_READ = 2'd2,
        ACT_NOP  = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_LOAD, S_POS_RD, S_MUL, S_ACC_RD, S_ACC_WR,
        S_SUM_RD, S_SUM_CAP, S_SHIFT, S_SQ, S_SQRT, S_LEN_CHK, S_DIV,
        S_RES_OUT, S_ZERO_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_POS_RD, OP_MUL, OP_ACC_RD, OP_ACC_WR, OP_SUM_RD,
        OP_SUM_CAP, OP_SHIFT, OP_SQ, OP_SQRT, OP_DIV, OP_OUT, OP_OUT_ZERO
    } t_dp_op;

    typedef struct packed {
        t_dp_op            op;
        logic [STEP_W-1:0] step;
        logic [1:0]        comp;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       slot_ok;
        logic       corners_ok;
        logic       big;
        logic       len_zero;
        logic       out_full;
    } t_status;

    typedef struct packed {
        logic [1:0]              action;
        logic [SLOT_W-1:0]       vertex_slot;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [SLOT_W-1:0]       corner_a;
        logic [SLOT_W-1:0]       corner_b;
        logic [SLOT_W-1:0]       corner_c;
    } t_item;

    typedef struct packed {
        logic [SLOT_W-1:0]       out_slot;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic                    zero_length;
    } t_result;

    function automatic logic slot_ok(logic [SLOT_W-1:0] s);
        return 32'(s) < 32'(VERTEX_SLOTS);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(logic [SLOT_W-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return w[ADDR_W-1:0];
    endfunction

    // Add a face component with clamping to the signed accumulator range.
    function automatic logic [SUM_WIDTH-1:0] sat_add(logic [SUM_WIDTH-1:0] acc,
                                                     logic [FACE_W-1:0] f);
        logic signed [SUM_WIDTH:0] s;
        s = $signed({acc[SUM_WIDTH-1], acc}) + (SUM_WIDTH+1)'($signed(f));
        if (s[SUM_WIDTH] != s[SUM_WIDTH-1]) begin
            return s[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end
        return s[SUM_WIDTH-1:0];
    endfunction

    function automatic logic [SUM_WIDTH-1:0] mag(logic [SUM_WIDTH-1:0] v);
        return v[SUM_WIDTH-1] ? (~v + SUM_WIDTH'(1)) : v;
    endfunction

endpackage

// File: rtl/vng_if.sv
interface vng_in_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              action;
    logic [9:0]              vertex_slot;
    logic signed [15:0]      pos_x;
    logic signed [15:0]      pos_y;
    logic signed [15:0]      pos_z;
    logic [9:0]              corner_a;
    logic [9:0]              corner_b;
    logic [9:0]              corner_c;

    modport source (output valid, action, vertex_slot, pos_x, pos_y, pos_z,
                    corner_a, corner_b, corner_c, input ready);
    modport sink (input valid, action, vertex_slot, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, output ready);
endinterface

interface vng_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         out_slot;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               zero_length;

    modport source (output valid, out_slot, normal_x, normal_y, normal_z, zero_length,
                    input ready);
    modport sink (input valid, out_slot, normal_x, normal_y, normal_z, zero_length,
                  output ready);
endinterface

// File: rtl/vng_ctrl.sv
module vng_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    output logic             o_in_ready,
    input  vng_pkg::t_status i_st,
    output vng_pkg::t_cmd    o_cmd
);
    import vng_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_comp, n_comp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_comp  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_comp  <= n_comp;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_accept) n_state = S_DISPATCH;
            S_DISPATCH: begin
                case (t_action'(i_st.action))
                    ACT_LOAD: n_state = i_st.slot_ok ? S_LOAD : S_IDLE;
                    ACT_TRI:  n_state = i_st.corners_ok ? S_POS_RD : S_IDLE;
                    ACT_READ: n_state = i_st.slot_ok ? S_SUM_RD : S_ZERO_OUT;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_LOAD:     n_state = S_IDLE;
            S_POS_RD:   if (r_step == POS_LAST) n_state = S_MUL;
            S_MUL:      if (r_step == MUL_LAST) n_state = S_ACC_RD;
            S_ACC_RD:   n_state = S_ACC_WR;
            S_ACC_WR:   n_state = (r_comp == COMP_LAST) ? S_IDLE : S_ACC_RD;
            S_SUM_RD:   n_state = S_SUM_CAP;
            S_SUM_CAP:  n_state = S_SHIFT;
            S_SHIFT:    if (!i_st.big) n_state = S_SQ;
            S_SQ:       if (r_step == SQ_LAST) n_state = S_SQRT;
            S_SQRT:     if (r_step == SQRT_LAST) n_state = S_LEN_CHK;
            S_LEN_CHK:  n_state = i_st.len_zero ? S_ZERO_OUT : S_DIV;
            S_DIV:      if (r_step == DIV_LAST && r_comp == COMP_LAST) n_state = S_RES_OUT;
            S_RES_OUT:  if (!i_st.out_full) n_state = S_IDLE;
            S_ZERO_OUT: if (!i_st.out_full) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Step and component counters; step clears on a state change
    always_comb begin
        n_step = (n_state != r_state) ? '0 : r_step + STEP_W'(1);
        n_comp = r_comp;
        case (r_state)
            S_MUL:    n_comp = '0;
            S_ACC_WR: n_comp = r_comp + 2'd1;
            S_LEN_CHK: n_comp = '0;
            S_DIV: begin
                if (r_step == DIV_LAST) begin
                    n_step = '0;
                    n_comp = r_comp + 2'd1;
                end
            end
            default: n_comp = r_comp;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.step = r_step;
        o_cmd.comp = r_comp;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE:     o_in_ready = 1'b1;
            S_LOAD:     o_cmd.op = OP_LOAD;
            S_POS_RD:   o_cmd.op = OP_POS_RD;
            S_MUL:      o_cmd.op = OP_MUL;
            S_ACC_RD:   o_cmd.op = OP_ACC_RD;
            S_ACC_WR:   o_cmd.op = OP_ACC_WR;
            S_SUM_RD:   o_cmd.op = OP_SUM_RD;
            S_SUM_CAP:  o_cmd.op = OP_SUM_CAP;
            S_SHIFT:    if (i_st.big) o_cmd.op = OP_SHIFT;
            S_SQ:       o_cmd.op = OP_SQ;
            S_SQRT:     o_cmd.op = OP_SQRT;
            S_DIV:      o_cmd.op = OP_DIV;
            S_RES_OUT:  if (!i_st.out_full) o_cmd.op = OP_OUT;
            S_ZERO_OUT: if (!i_st.out_full) o_cmd.op = OP_OUT_ZERO;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

`include "vertex_normal_generator_assert.svh"
    `VNG_ASSERT_NXT(a_accept_dispatch, i_accept, r_state == S_DISPATCH, "accept lost")
    `VNG_ASSERT_NXT(a_sqrt_done, r_state == S_SQRT && r_step == SQRT_LAST, r_state == S_LEN_CHK, "sqrt length wrong")
    `VNG_ASSERT_NOW(a_out_free, o_cmd.op == OP_OUT || o_cmd.op == OP_OUT_ZERO, !i_st.out_full, "result overwritten")

endmodule

// File: rtl/vng_dp.sv
module vng_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  vng_pkg::t_item   i_item,
    input  vng_pkg::t_cmd    i_cmd,
    output vng_pkg::t_status o_st,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output vng_pkg::t_result o_res
);
    import vng_pkg::*;

    logic [PFULL_W-1:0]     pos_mem [VERTEX_SLOTS];
    logic [3*SUM_WIDTH-1:0] sum_mem [VERTEX_SLOTS];

    t_item                  r_item;
    logic [PFULL_W-1:0]     r_pos_q, r_pa, r_pb, r_pc;
    logic [3*SUM_WIDTH-1:0] r_sum_q;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [FACE_W-1:0] r_fx, r_fy, r_fz;
    logic [2:0]             r_neg;
    logic [SUM_WIDTH-1:0]   r_t0, r_t1, r_t2;
    logic [SQP_W-1:0]       r_sqp;
    logic [Q_W-1:0]         r_q;
    logic [REM_W-1:0]       r_rem;
    logic [ROOT_W-1:0]      r_root;
    logic [DREM_W-1:0]      r_remd;
    logic [QUO_W-1:0]       r_numlo;
    logic [QUO_W-1:0]       r_quo;
    logic [NRM_W-1:0]       r_nx, r_ny, r_nz;
    logic                   r_out_valid;
    t_result                r_res;

    logic [SLOT_W-1:0]      corner;
    logic [ADDR_W-1:0]      addr;
    logic signed [EDGE_W-1:0] e1x, e1y, e1z, e2x, e2y, e2z, ma, mb;
    logic [2:0]             j;
    logic signed [FACE_W-1:0] delta;
    logic [SUM_WIDTH-1:0]   sx, sy, sz;
    logic [SUM_WIDTH-1:0]   tsel;
    logic [REM_W+1:0]       rem_sh, trial;
    logic                   sq_ge;
    logic [NUM_W-1:0]       num;
    logic [DREM_W:0]        drem_sh;
    logic                   d_ge;
    logic [QUO_W-1:0]       quo_n;
    logic [NRM_W-1:0]       nrm;

    always_comb begin
        case (i_cmd.op == OP_POS_RD ? i_cmd.step[1:0] : i_cmd.comp)
            2'd0:    corner = r_item.corner_a;
            2'd1:    corner = r_item.corner_b;
            default: corner = r_item.corner_c;
        endcase
        case (i_cmd.op)
            OP_POS_RD, OP_ACC_RD, OP_ACC_WR: addr = slot_addr(corner);
            default:                        addr = slot_addr(r_item.vertex_slot);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) r_item <= i_item;
        if (i_cmd.op == OP_LOAD) begin
            pos_mem[addr] <= {r_item.pos_x, r_item.pos_y, r_item.pos_z};
            sum_mem[addr] <= '0;
        end
        if (i_cmd.op == OP_ACC_WR) sum_mem[addr] <= {sat_add(sx, r_fx),
                                                    sat_add(sy, r_fy),
                                                    sat_add(sz, r_fz)};
        if (i_cmd.op == OP_POS_RD && i_cmd.step < POS_LAST) r_pos_q <= pos_mem[addr];
        if (i_cmd.op == OP_ACC_RD || i_cmd.op == OP_SUM_RD) r_sum_q <= sum_mem[addr];
    end

    assign sx = r_sum_q[3*SUM_WIDTH-1:2*SUM_WIDTH];
    assign sy = r_sum_q[2*SUM_WIDTH-1:SUM_WIDTH];
    assign sz = r_sum_q[SUM_WIDTH-1:0];

    // Edges from corner A
    assign e1x = EDGE_W'($signed(r_pb[47:32])) - EDGE_W'($signed(r_pa[47:32]));
    assign e1y = EDGE_W'($signed(r_pb[31:16])) - EDGE_W'($signed(r_pa[31:16]));
    assign e1z = EDGE_W'($signed(r_pb[15:0]))  - EDGE_W'($signed(r_pa[15:0]));
    assign e2x = EDGE_W'($signed(r_pc[47:32])) - EDGE_W'($signed(r_pa[47:32]));
    assign e2y = EDGE_W'($signed(r_pc[31:16])) - EDGE_W'($signed(r_pa[31:16]));
    assign e2z = EDGE_W'($signed(r_pc[15:0]))  - EDGE_W'($signed(r_pa[15:0]));

    assign j = i_cmd.step[2:0] - 3'd1;

    always_comb begin
        case (i_cmd.step[2:0])
            3'd0:    begin ma = e1y; mb = e2z; end
            3'd1:    begin ma = e1z; mb = e2y; end
            3'd2:    begin ma = e1z; mb = e2x; end
            3'd3:    begin ma = e1x; mb = e2z; end
            3'd4:    begin ma = e1x; mb = e2y; end
            default: begin ma = e1y; mb = e2x; end
        endcase
        delta = j[0] ? -FACE_W'(r_prod) : FACE_W'(r_prod);
    end

    // Cross product: one product per cycle, folded into the face normal next cycle
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_POS_RD: begin
                case (i_cmd.step[1:0])
                    2'd1:    r_pa <= r_pos_q;
                    2'd2:    r_pb <= r_pos_q;
                    2'd3:    r_pc <= r_pos_q;
                    default: r_pa <= r_pa;
                endcase
            end
            OP_MUL: begin
                if (i_cmd.step < MUL_LAST) r_prod <= ma * mb;
                if (i_cmd.step == '0) begin
                    r_fx <= '0;
                    r_fy <= '0;
                    r_fz <= '0;
                end else begin
                    case (j[2:1])
                        2'd0:    r_fx <= r_fx + delta;
                        2'd1:    r_fy <= r_fy + delta;
                        default: r_fz <= r_fz + delta;
                    endcase
                end
            end
            default: r_prod <= r_prod;
        endcase
    end

    // Normalization datapath
    always_comb begin
        case (i_cmd.op == OP_SQ ? i_cmd.step[1:0] : i_cmd.comp)
            2'd0:    tsel = r_t0;
            2'd1:    tsel = r_t1;
            default: tsel = r_t2;
        endcase
        rem_sh = {r_rem, r_q[Q_W-1:Q_W-2]};
        trial  = (REM_W+2)'({r_root, 2'b01});
        sq_ge  = rem_sh >= trial;
        num    = NUM_W'({tsel[MAG_LIM-1:0], {FRAC_W{1'b0}}}) + NUM_W'(r_root >> 1);
        drem_sh = {r_remd, r_numlo[QUO_W-1]};
        d_ge   = drem_sh >= (DREM_W+1)'(r_root);
        quo_n  = {r_quo[QUO_W-2:0], d_ge};
        nrm    = r_neg[2 - i_cmd.comp] ? -NRM_W'(quo_n) : NRM_W'(quo_n);
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_SUM_CAP: begin
                r_neg <= {sx[SUM_WIDTH-1], sy[SUM_WIDTH-1], sz[SUM_WIDTH-1]};
                r_t0  <= mag(sx);
                r_t1  <= mag(sy);
                r_t2  <= mag(sz);
            end
            OP_SHIFT: begin
                r_t0 <= r_t0 >> 1;
                r_t1 <= r_t1 >> 1;
                r_t2 <= r_t2 >> 1;
            end
            OP_SQ: begin
                if (i_cmd.step < SQ_LAST)
                    r_sqp <= tsel[MAG_LIM-1:0] * tsel[MAG_LIM-1:0];
                if (i_cmd.step == '0) begin
                    r_q    <= '0;
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_q <= r_q + Q_W'(r_sqp);
                end
            end
            OP_SQRT: begin
                r_q <= r_q << 2;
                if (sq_ge) begin
                    r_rem  <= REM_W'(rem_sh - trial);
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= REM_W'(rem_sh);
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
            end
            OP_DIV: begin
                if (i_cmd.step == '0) begin
                    r_remd  <= DREM_W'(num[NUM_W-1:QUO_W]);
                    r_numlo <= num[QUO_W-1:0];
                    r_quo   <= '0;
                end else begin
                    r_remd  <= d_ge ? DREM_W'(drem_sh - (DREM_W+1)'(r_root))
                                    : drem_sh[DREM_W-1:0];
                    r_numlo <= r_numlo << 1;
                    r_quo   <= quo_n;
                    if (i_cmd.step == DIV_LAST) begin
                        case (i_cmd.comp)
                            2'd0:    r_nx <= nrm;
                            2'd1:    r_ny <= nrm;
                            default: r_nz <= nrm;
                        endcase
                    end
                end
            end
            default: r_q <= r_q;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT || i_cmd.op == OP_OUT_ZERO) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            r_res <= '{out_slot: r_item.vertex_slot, normal_x: r_nx, normal_y: r_ny,
                       normal_z: r_nz, zero_length: 1'b0};
        end else if (i_cmd.op == OP_OUT_ZERO) begin
            r_res <= '{out_slot: r_item.vertex_slot, normal_x: '0, normal_y: '0,
                       normal_z: '0, zero_length: 1'b1};
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_res           = r_res;
    assign o_st.action     = r_item.action;
    assign o_st.slot_ok    = slot_ok(r_item.vertex_slot);
    assign o_st.corners_ok = slot_ok(r_item.corner_a) && slot_ok(r_item.corner_b)
                             && slot_ok(r_item.corner_c);
    assign o_st.big        = (|r_t0[SUM_WIDTH-1:MAG_LIM]) || (|r_t1[SUM_WIDTH-1:MAG_LIM])
                             || (|r_t2[SUM_WIDTH-1:MAG_LIM]);
    assign o_st.len_zero   = (r_root == '0);
    assign o_st.out_full   = r_out_valid;

endmodule

// File: rtl/vertex_normal_generator.sv
// Area-weighted vertex normals in fixed point. A load request stores a Q8.8
// position in a vertex slot and clears that slot's normal sum. A triangle
// request adds the cross product (B-A)x(C-A) with saturation to the sums of
// corners A, B and C; a corner listed twice gets it twice. A read request
// returns the slot's sum scaled to unit length in Q1.14 (or zeros with
// zero_length set when the sum is zero). Requests are handled one at a time
// by a sequencer over single-port position and sum memories: a triangle
// makes three position reads, six products on a shared multiplier and three
// read-modify-writes; a read first shifts the sums right by k (0..18) until
// the largest component is below 2^30, and its bit-per-cycle square root and
// one 15-bit divider, run once per component, dominate. A finished result
// waits in an output register while the next request is accepted. Reading a
// slot that was never loaded gives undefined data.
module vertex_normal_generator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vng_in_if.sink     i_in,
    vng_out_if.source  o_out
);
    import vng_pkg::*;

    t_status st;
    t_cmd    cmd;
    t_item   item;
    t_result res;
    logic    in_ready;
    logic    accept;
    logic    out_valid;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid & in_ready;
    assign item       = '{action: i_in.action, vertex_slot: i_in.vertex_slot,
                          pos_x: i_in.pos_x, pos_y: i_in.pos_y, pos_z: i_in.pos_z,
                          corner_a: i_in.corner_a, corner_b: i_in.corner_b,
                          corner_c: i_in.corner_c};

    vng_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .o_in_ready (in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    vng_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_res       (res)
    );

    // Drive the result channel straight from the output register
    assign o_out.valid       = out_valid;
    assign o_out.out_slot    = res.out_slot;
    assign o_out.normal_x    = res.normal_x;
    assign o_out.normal_y    = res.normal_y;
    assign o_out.normal_z    = res.normal_z;
    assign o_out.zero_length = res.zero_length;

endmodule
